@@ sv/tmrb_pkg.sv @@
// ----------------------------------------------------------------------------
// tmrb_pkg
// Operation and status codes used by the ring buffer top module.
// ----------------------------------------------------------------------------
package tmrb_pkg;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_PREPEND     = 3'd1,
    OP_DROP_OLDEST = 3'd2,
    OP_DROP_NEWEST = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_CUR_RESET   = 3'd5,
    OP_CUR_SEEK    = 3'd6,
    OP_CUR_READ    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_ORDER     = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_CURSOR    = 3'd4
  } status_t;

endpackage

@@ sv/tmrb_ram.sv @@
// ----------------------------------------------------------------------------
// tmrb_ram
// Byte-wide ring storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tmrb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/timestamped_message_ring_buffer_top.sv @@
// ----------------------------------------------------------------------------
// timestamped_message_ring_buffer_top
// Ring of timestamped variable-length records with one read cursor.
// ----------------------------------------------------------------------------
// channel | signals                                        | handshake
// in      | operation stamp msg_len msg_bytes replace_ok  | in_valid/in_ready
// out     | status rec_time rec_len rec_bytes event_total  | out_valid/out_ready
//         | bytes_used                                     |
// One item at a time: taken in S_IDLE, decoded in S_DECIDE, result presented in S_DONE.
// A header is read through the one registered read port, then S_HWAIT decides.
// Append/prepend: a header check, then the record write; each eviction reads a header.
// Drops and seek walk records header by header; cursor read fetches header and payload.
// Reset clears the pointers and count; the memory needs no clearing pass.
// A waiting result holds until taken; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module timestamped_message_ring_buffer_top #(
  parameter int RING_BYTES   = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_PAYLOAD  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] stamp,
  input  logic [3:0]  msg_len,
  input  logic [63:0] msg_bytes,
  input  logic        replace_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] rec_time,
  output logic [3:0]  rec_len,
  output logic [63:0] rec_bytes,
  output logic [9:0]  event_total,
  output logic [12:0] bytes_used
);
  localparam int AW  = $clog2(RING_BYTES);
  localparam int HDR = (HEADER_BYTES < 5) ? 5 : HEADER_BYTES;
  localparam int UW  = AW + 1;
  localparam int CW  = 10;
  localparam int BW  = 5;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_HREAD, S_HWAIT, S_WRITE, S_PREAD, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    H_APP_ORDER, H_PRE_ORDER, H_EVICT, H_DROP_OLD, H_DROP_NEW, H_SEEK, H_READ
  } hmode_t;

  state_t          state;
  hmode_t          hmode;
  logic [2:0]      op;
  logic [31:0]     tstamp;
  logic [3:0]      len;
  logic [63:0]     bytes;
  logic            rep;
  logic [AW-1:0]   oldest_ptr, write_ptr, newest_ptr, cursor_ptr;
  logic [CW-1:0]   record_count;
  logic            cursor_valid;
  logic            hit, found;
  logic [AW-1:0]   hbase, wbase, prevp, kstart, kprev;
  logic [CW-1:0]   idx, keep;
  logic [BW-1:0]   bcnt;
  logic [31:0]     htime;
  logic [3:0]      hlen;
  logic [63:0]     pbuf;
  logic [2:0]      st;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;

  logic [UW-1:0]   used, free_b, sz;
  logic [3:0]      hlen_c, rlen_c;
  logic [AW-1:0]   hnext;

  tmrb_ram #(.DEPTH(RING_BYTES), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    if (record_count == '0) begin
      used = '0;
    end else if (write_ptr == oldest_ptr) begin
      used = UW'(RING_BYTES);
    end else begin
      used = {1'b0, AW'(write_ptr - oldest_ptr)};
    end
    free_b = UW'(RING_BYTES) - used;
    sz     = UW'(HDR) + UW'(len);
    rlen_c = (rdata[3:0] > 4'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD) : rdata[3:0];
    hlen_c = hlen;
    hnext  = hbase + AW'(HDR) + AW'(hlen);
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    we    = (state == S_WRITE);
    waddr = wbase + AW'(bcnt);
    if (bcnt < BW'(4)) begin
      wdata = tstamp[8*bcnt[1:0] +: 8];
    end else if (bcnt == BW'(4)) begin
      wdata = {4'd0, len};
    end else if (bcnt < BW'(HDR)) begin
      wdata = 8'd0;
    end else begin
      wdata = bytes[8*(3'(bcnt - BW'(HDR))) +: 8];
    end
    raddr = hbase + AW'(bcnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      oldest_ptr   <= '0;
      write_ptr    <= '0;
      newest_ptr   <= '0;
      cursor_ptr   <= '0;
      record_count <= '0;
      cursor_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op     <= operation;
            tstamp <= stamp;
            len    <= msg_len;
            bytes  <= msg_bytes;
            rep    <= replace_ok;
            st     <= tmrb_pkg::ST_OK;
            hit    <= 1'b0;
            found  <= 1'b0;
            pbuf   <= '0;
            htime  <= '0;
            hlen   <= '0;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          bcnt  <= '0;
          state <= S_DONE;
          case (tmrb_pkg::op_t'(op))
            tmrb_pkg::OP_APPEND, tmrb_pkg::OP_PREPEND: begin
              if (len > 4'(MAX_PAYLOAD)) begin
                st <= tmrb_pkg::ST_TOO_LONG;
              end else if (op == tmrb_pkg::OP_APPEND) begin
                if (sz > free_b && (!rep || sz > UW'(RING_BYTES))) begin
                  st <= tmrb_pkg::ST_FULL;
                end else if (record_count != '0) begin
                  hbase <= newest_ptr; hmode <= H_APP_ORDER; state <= S_HREAD;
                end else begin
                  hmode <= H_EVICT; hbase <= oldest_ptr; state <= S_PREAD;
                end
              end else begin
                if (sz > free_b) begin
                  st <= tmrb_pkg::ST_FULL;
                end else if (record_count != '0) begin
                  hbase <= oldest_ptr; hmode <= H_PRE_ORDER; state <= S_HREAD;
                end else begin
                  hmode <= H_PRE_ORDER; state <= S_PREAD;
                end
              end
            end
            tmrb_pkg::OP_DROP_OLDEST: begin
              hbase <= oldest_ptr; hmode <= H_DROP_OLD;
              state <= (record_count != '0) ? S_HREAD : S_PREAD;
            end
            tmrb_pkg::OP_DROP_NEWEST: begin
              hbase <= oldest_ptr; prevp <= oldest_ptr; idx <= '0;
              keep <= record_count; hmode <= H_DROP_NEW;
              state <= (record_count != '0) ? S_HREAD : S_DONE;
            end
            tmrb_pkg::OP_CLEAR: begin
              oldest_ptr <= '0; write_ptr <= '0; newest_ptr <= '0;
              record_count <= '0; cursor_ptr <= '0; cursor_valid <= 1'b0;
            end
            tmrb_pkg::OP_CUR_RESET: begin
              if (record_count != '0) begin
                cursor_ptr <= oldest_ptr; cursor_valid <= 1'b1;
              end else begin
                cursor_valid <= 1'b0; st <= tmrb_pkg::ST_CURSOR;
              end
            end
            tmrb_pkg::OP_CUR_SEEK: begin
              if (!cursor_valid || record_count == '0) begin
                st <= tmrb_pkg::ST_CURSOR;
              end else begin
                hbase <= cursor_ptr; idx <= '0; hmode <= H_SEEK; state <= S_HREAD;
              end
            end
            default: begin
              if (!cursor_valid || record_count == '0) begin
                st <= tmrb_pkg::ST_CURSOR;
              end else begin
                hbase <= cursor_ptr; hmode <= H_READ; state <= S_HREAD;
              end
            end
          endcase
        end
        S_HREAD: begin
          // issue address bcnt; data for bcnt-1 arrives now
          if (bcnt != '0) begin
            if (bcnt <= BW'(4)) begin
              htime[8*(2'(bcnt - BW'(1))) +: 8] <= rdata;
            end else if (bcnt == BW'(5)) begin
              hlen <= rlen_c;
            end else if (bcnt > BW'(HDR)) begin
              pbuf[8*(3'(bcnt - BW'(HDR) - BW'(1))) +: 8] <= rdata;
            end
          end
          if (hmode == H_READ) begin
            if (bcnt > BW'(5) && bcnt >= BW'(HDR) + BW'(hlen)) begin
              state <= S_HWAIT;
            end else if (bcnt == BW'(5) && BW'(HDR) + BW'(rlen_c) <= BW'(5)) begin
              state <= S_HWAIT;
            end
            bcnt <= bcnt + BW'(1);
          end else if (bcnt == BW'(5)) begin
            state <= S_HWAIT;
          end else begin
            bcnt <= bcnt + BW'(1);
          end
        end
        S_HWAIT: begin
          bcnt  <= '0;
          state <= S_HREAD;
          case (hmode)
            H_APP_ORDER: begin
              if (htime > tstamp) begin
                st <= tmrb_pkg::ST_ORDER; state <= S_DONE;
              end else begin
                hmode <= H_EVICT; hbase <= oldest_ptr; state <= S_PREAD;
              end
            end
            H_PRE_ORDER: begin
              if (htime < tstamp) begin
                st <= tmrb_pkg::ST_ORDER; state <= S_DONE;
              end else begin
                state <= S_PREAD;
              end
            end
            H_EVICT: begin
              if (cursor_valid && cursor_ptr == oldest_ptr) hit <= 1'b1;
              oldest_ptr   <= hnext;
              hbase        <= hnext;
              record_count <= record_count - CW'(1);
              state        <= S_PREAD;
            end
            H_DROP_OLD: begin
              if (htime < tstamp) begin
                if (cursor_valid && cursor_ptr == oldest_ptr) cursor_valid <= 1'b0;
                oldest_ptr   <= hnext;
                hbase        <= hnext;
                record_count <= record_count - CW'(1);
                state        <= S_PREAD;
              end else begin
                state <= S_DONE;
              end
            end
            H_DROP_NEW: begin
              if (!found && htime > tstamp) begin
                found <= 1'b1; keep <= idx; kstart <= hbase; kprev <= prevp;
                if (cursor_valid && cursor_ptr == hbase) cursor_valid <= 1'b0;
              end else if (found && cursor_valid && cursor_ptr == hbase) begin
                cursor_valid <= 1'b0;
              end
              prevp <= hbase;
              hbase <= hnext;
              idx   <= idx + CW'(1);
              if (idx + CW'(1) >= record_count) state <= S_PREAD;
            end
            H_SEEK: begin
              if (htime >= tstamp) begin
                cursor_ptr <= hbase; state <= S_DONE;
              end else if (hbase == newest_ptr || idx + CW'(1) >= record_count) begin
                st <= tmrb_pkg::ST_CURSOR; state <= S_DONE;
              end else begin
                hbase <= hnext; idx <= idx + CW'(1);
              end
            end
            default: begin
              if (hbase == newest_ptr) cursor_valid <= 1'b0;
              else cursor_ptr <= hnext;
              state <= S_DONE;
            end
          endcase
        end
        S_PREAD: begin
          bcnt  <= '0;
          state <= S_DONE;
          case (hmode)
            H_EVICT: begin
              if (record_count != '0 && free_b < sz) begin
                state <= S_HREAD;
              end else begin
                if (record_count == '0) oldest_ptr <= write_ptr;
                newest_ptr <= write_ptr;
                wbase      <= write_ptr;
                write_ptr  <= write_ptr + AW'(sz);
                state      <= S_WRITE;
              end
            end
            H_PRE_ORDER: begin
              oldest_ptr <= oldest_ptr - AW'(sz);
              if (record_count == '0) newest_ptr <= oldest_ptr - AW'(sz);
              wbase <= oldest_ptr - AW'(sz);
              state <= S_WRITE;
            end
            H_DROP_OLD: begin
              if (record_count != '0) begin
                state <= S_HREAD;
              end else begin
                write_ptr <= oldest_ptr; newest_ptr <= oldest_ptr;
              end
            end
            default: begin
              if (found) begin
                write_ptr    <= kstart;
                record_count <= keep;
                newest_ptr   <= (keep != '0) ? kprev : kstart;
              end
            end
          endcase
        end
        S_WRITE: begin
          if (UW'(bcnt) + UW'(1) >= sz) begin
            record_count <= record_count + CW'(1);
            if (hit) cursor_ptr <= oldest_ptr;
            state <= S_DONE;
          end
          bcnt <= bcnt + BW'(1);
        end
        default: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= st;
            bytes_used  <= 13'(used);
            event_total <= record_count;
            if (op == tmrb_pkg::OP_CUR_READ && st == tmrb_pkg::ST_OK) begin
              rec_time  <= htime;
              rec_len   <= hlen_c;
              rec_bytes <= pbuf;
            end else begin
              rec_time  <= '0;
              rec_len   <= '0;
              rec_bytes <= '0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
